// ===== rtl/iadm_pkg.sv =====
// ----------------------------------------------------------------------------
// iadm_pkg
// Shared constants, operation codes and control types of the deadzone mixer.
// ----------------------------------------------------------------------------
package iadm_pkg;

	// default accumulator width
	localparam int ACCUM_BITS_DEF = 24;

	// deadzone limit, 0.95 in Q0.15
	localparam logic [14:0] DZ_MAX = 15'd31130;

	// one in Q1.15 as an unsigned 17 bit value
	localparam logic [16:0] ONE_Q15 = 17'd32768;

	// steps of the square root and division units
	localparam int ITER_STEPS = 16;
	localparam int ITER_BITS  = $clog2(ITER_STEPS);

	// binding kinds
	localparam logic [1:0] CMD_DIGITAL = 2'd0;
	localparam logic [1:0] CMD_TRIGGER = 2'd1;
	localparam logic [1:0] CMD_STICK   = 2'd2;

	// configuration register indexes
	localparam logic CFG_STICK_DZ   = 1'b0;
	localparam logic CFG_TRIGGER_DZ = 1'b1;

	// datapath operations
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_SQM  = 4'd2;
	localparam logic [3:0] OP_SQP  = 4'd3;
	localparam logic [3:0] OP_DZC  = 4'd4;
	localparam logic [3:0] OP_SQRT = 4'd5;
	localparam logic [3:0] OP_NUM  = 4'd6;
	localparam logic [3:0] OP_DEN  = 4'd7;
	localparam logic [3:0] OP_TRG  = 4'd8;
	localparam logic [3:0] OP_DIV  = 4'd9;
	localparam logic [3:0] OP_VAL  = 4'd10;
	localparam logic [3:0] OP_WGT  = 4'd11;
	localparam logic [3:0] OP_ACC  = 4'd12;

	typedef struct packed {
		logic [3:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       last;
		logic       zero;
		logic       out_full;
	} dp_status_t;

endpackage

// ===== rtl/iadm_if.sv =====
// ----------------------------------------------------------------------------
// iadm_if
// Binding input channel and frame result channel of the deadzone mixer.
// ----------------------------------------------------------------------------
interface iadm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic               held;
	logic signed [15:0] raw_main;
	logic signed [15:0] raw_partner;
	logic               to_y;
	logic signed [15:0] weight;
	logic               last_binding;

	modport source (output valid, command, held, raw_main, raw_partner, to_y, weight,
		last_binding, input ready);
	modport sink (input valid, command, held, raw_main, raw_partner, to_y, weight,
		last_binding, output ready);
endinterface

interface iadm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic               pressed;

	modport source (output valid, axis_x, axis_y, pressed, input ready);
	modport sink (input valid, axis_x, axis_y, pressed, output ready);
endinterface

// ===== rtl/iadm_ctrl.sv =====
// ----------------------------------------------------------------------------
// iadm_ctrl
// Sequencer that steps the datapath through one binding at a time.
// ----------------------------------------------------------------------------
module iadm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_command,
	output logic                  in_ready,
	input  iadm_pkg::dp_status_t  status,
	output iadm_pkg::dp_cmd_t     cmd
);
	import iadm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQM  = 4'd1;
	localparam logic [3:0] ST_SQP  = 4'd2;
	localparam logic [3:0] ST_DZC  = 4'd3;
	localparam logic [3:0] ST_SQRT = 4'd4;
	localparam logic [3:0] ST_NUM  = 4'd5;
	localparam logic [3:0] ST_DEN  = 4'd6;
	localparam logic [3:0] ST_TRG  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_VAL  = 4'd9;
	localparam logic [3:0] ST_WGT  = 4'd10;
	localparam logic [3:0] ST_ACC  = 4'd11;

	localparam logic [ITER_BITS-1:0] CNT_LAST = ITER_BITS'(ITER_STEPS - 1);

	logic [3:0]           state_q, state_d;
	logic [ITER_BITS-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and operation
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					case (in_command)
						CMD_STICK:   state_d = ST_SQM;
						CMD_TRIGGER: state_d = ST_TRG;
						default:     state_d = ST_WGT;
					endcase
				end
			end
			ST_SQM: begin
				cmd.op  = OP_SQM;
				state_d = ST_SQP;
			end
			ST_SQP: begin
				cmd.op  = OP_SQP;
				state_d = ST_DZC;
			end
			ST_DZC: begin
				cmd.op  = OP_DZC;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (status.zero) begin
					state_d = ST_VAL;
				end else begin
					cmd.op = OP_SQRT;
					cnt_d  = cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) state_d = ST_NUM;
				end
			end
			ST_NUM: begin
				cmd.op  = OP_NUM;
				state_d = ST_DEN;
			end
			ST_DEN: begin
				cmd.op  = OP_DEN;
				state_d = ST_DIV;
			end
			ST_TRG: begin
				cmd.op  = OP_TRG;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.zero) begin
					state_d = ST_VAL;
				end else begin
					cmd.op = OP_DIV;
					cnt_d  = cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) state_d = ST_VAL;
				end
			end
			ST_VAL: begin
				cmd.op  = OP_VAL;
				state_d = ST_WGT;
			end
			ST_WGT: begin
				cmd.op  = OP_WGT;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				// hold a last binding while a result is still waiting to be taken
				if (!(status.last && status.out_full)) begin
					cmd.op  = OP_ACC;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/iadm_dpath.sv =====
// ----------------------------------------------------------------------------
// iadm_dpath
// Deadzone arithmetic, shared multiplier, square root and divider steps,
// saturating accumulators and the result register.
// ----------------------------------------------------------------------------
module iadm_dpath #(
	parameter int ACCUM_BITS = iadm_pkg::ACCUM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iadm_pkg::dp_cmd_t    cmd,
	output iadm_pkg::dp_status_t status,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [14:0]          cfg_wdata,
	input  logic [1:0]           in_command,
	input  logic                 in_held,
	input  logic signed [15:0]   in_raw_main,
	input  logic signed [15:0]   in_raw_partner,
	input  logic                 in_to_y,
	input  logic signed [15:0]   in_weight,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   axis_x,
	output logic signed [15:0]   axis_y,
	output logic                 pressed
);
	import iadm_pkg::*;

	localparam logic signed [ACCUM_BITS:0] SAT_HI =
		(ACCUM_BITS+1)'({1'b0, {(ACCUM_BITS-1){1'b1}}});
	localparam logic signed [ACCUM_BITS:0] SAT_LO = ~SAT_HI;
	localparam logic signed [ACCUM_BITS-1:0] OUT_HI = ACCUM_BITS'(32767);
	localparam logic signed [ACCUM_BITS-1:0] OUT_LO = ACCUM_BITS'(-32768);

	// configuration
	logic [14:0] stick_dz_q, trig_dz_q;
	logic [14:0] wdata_lim;

	// latched binding
	logic [1:0]         command_q;
	logic               held_q, to_y_q, last_q;
	logic signed [15:0] main_q, partner_q, weight_q;

	// working registers
	logic [31:0]              m2_q, sq_n_q, sq_res_q, sq_bit_q;
	logic [31:0]              rem_q;
	logic [15:0]              low_q, quo_q;
	logic                     zero_q;
	logic signed [15:0]       value_q;
	logic signed [19:0]       contrib_q;
	logic signed [ACCUM_BITS-1:0] sum_x_q, sum_y_q;
	logic                     out_valid_q;
	logic signed [15:0]       axis_x_q, axis_y_q;
	logic                     pressed_q;

	// shared multiplier
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod;

	logic [16:0] abs_main, mag_minus_dz, one_minus_sdz;
	logic [15:0] mag;
	logic [15:0] trig_diff;
	logic        trig_zero;
	logic [31:0] sq_try;
	logic [32:0] div_try;
	logic signed [35:0] prod_adj;
	logic signed [ACCUM_BITS:0] acc_sum;
	logic signed [ACCUM_BITS-1:0] acc_sat;
	logic signed [ACCUM_BITS-1:0] nx_x, nx_y;

	assign wdata_lim    = (cfg_wdata > DZ_MAX) ? DZ_MAX : cfg_wdata;
	assign abs_main     = main_q[15] ? 17'(-$signed({main_q[15], main_q})) : 17'(main_q);
	assign mag          = sq_res_q[15:0];
	assign mag_minus_dz = 17'(mag) - 17'(stick_dz_q);
	assign one_minus_sdz = ONE_Q15 - 17'(stick_dz_q);
	assign trig_zero    = (main_q <= $signed({1'b0, trig_dz_q}));
	assign trig_diff    = 16'(main_q) - 16'(trig_dz_q);
	assign sq_try       = sq_res_q + sq_bit_q;
	assign div_try      = {rem_q, low_q[15]};

	// multiplier operand select
	always_comb begin
		case (cmd.op)
			OP_SQM:  begin mul_a = 18'(main_q);        mul_b = 18'(main_q); end
			OP_SQP:  begin mul_a = 18'(partner_q);     mul_b = 18'(partner_q); end
			OP_DZC:  begin mul_a = 18'(stick_dz_q);    mul_b = 18'(stick_dz_q); end
			OP_NUM:  begin mul_a = 18'(abs_main);      mul_b = 18'(mag_minus_dz); end
			OP_DEN:  begin mul_a = 18'(mag);           mul_b = 18'(one_minus_sdz); end
			OP_WGT:  begin mul_a = 18'(value_q);       mul_b = 18'(weight_q); end
			default: begin mul_a = '0;                 mul_b = '0; end
		endcase
	end
	assign prod     = mul_a * mul_b;
	// truncate toward zero on the Q4.12 rescale
	assign prod_adj = prod[35] ? prod + 36'sd4095 : prod;

	// saturating accumulate into the selected component
	assign acc_sum = (to_y_q ? {sum_y_q[ACCUM_BITS-1], sum_y_q}
		: {sum_x_q[ACCUM_BITS-1], sum_x_q}) + (ACCUM_BITS+1)'(contrib_q);
	always_comb begin
		if (acc_sum > SAT_HI)      acc_sat = SAT_HI[ACCUM_BITS-1:0];
		else if (acc_sum < SAT_LO) acc_sat = SAT_LO[ACCUM_BITS-1:0];
		else                       acc_sat = acc_sum[ACCUM_BITS-1:0];
		nx_x = to_y_q ? sum_x_q : acc_sat;
		nx_y = to_y_q ? acc_sat : sum_y_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_dz_q <= '0;
			trig_dz_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STICK_DZ:   stick_dz_q <= wdata_lim;
				CFG_TRIGGER_DZ: trig_dz_q  <= wdata_lim;
				default: ;
			endcase
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				command_q <= in_command;
				held_q    <= in_held;
				main_q    <= in_raw_main;
				partner_q <= in_raw_partner;
				to_y_q    <= in_to_y;
				weight_q  <= in_weight;
				last_q    <= in_last;
				zero_q    <= 1'b0;
			end
			OP_SQM: m2_q <= 32'(prod);
			OP_SQP: m2_q <= m2_q + 32'(prod);
			OP_DZC: begin
				zero_q   <= (m2_q <= 32'(prod));
				sq_n_q   <= m2_q;
				sq_res_q <= '0;
				sq_bit_q <= 32'h4000_0000;
			end
			OP_SQRT: begin
				if (sq_n_q >= sq_try) begin
					sq_n_q   <= sq_n_q - sq_try;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_NUM: begin
				// numerator is the product shifted up by 15
				rem_q <= {1'b0, prod[31:1]};
				low_q <= {prod[0], 15'd0};
			end
			OP_DEN: m2_q <= 32'(prod);
			OP_TRG: begin
				zero_q <= trig_zero;
				rem_q  <= {17'd0, trig_diff[15:1]};
				low_q  <= {trig_diff[0], 15'd0};
				m2_q   <= 32'(ONE_Q15 - 17'(trig_dz_q));
			end
			OP_DIV: begin
				if (div_try >= {1'b0, m2_q}) begin
					rem_q <= 32'(div_try - {1'b0, m2_q});
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= div_try[31:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				low_q <= {low_q[14:0], 1'b0};
			end
			OP_VAL: begin
				if (zero_q)                         value_q <= '0;
				else if (!main_q[15] && quo_q[15])  value_q <= 16'sh7fff;
				else if (main_q[15] && quo_q > 16'h8000) value_q <= 16'sh8000;
				else if (main_q[15])                value_q <= 16'(-$signed({1'b0, quo_q}));
				else                                value_q <= $signed(quo_q);
			end
			OP_WGT: begin
				case (command_q)
					CMD_DIGITAL: contrib_q <= held_q ? 20'(weight_q) <<< 3 : '0;
					CMD_TRIGGER, CMD_STICK: contrib_q <= 20'(prod_adj >>> 12);
					default: contrib_q <= '0;
				endcase
			end
			default: ;
		endcase
	end

	// accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ACC) begin
				if (last_q) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
				end else begin
					sum_x_q <= nx_x;
					sum_y_q <= nx_y;
				end
			end
			if (cmd.op == OP_ACC && last_q) out_valid_q <= 1'b1;
			else if (out_ready)             out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACC && last_q) begin
			axis_x_q  <= (nx_x > OUT_HI) ? 16'sh7fff : (nx_x < OUT_LO) ? 16'sh8000 : nx_x[15:0];
			axis_y_q  <= (nx_y > OUT_HI) ? 16'sh7fff : (nx_y < OUT_LO) ? 16'sh8000 : nx_y[15:0];
			pressed_q <= (nx_x > 0) || (nx_y > 0);
		end
	end

	assign out_valid = out_valid_q;
	assign axis_x    = axis_x_q;
	assign axis_y    = axis_y_q;
	assign pressed   = pressed_q;

	assign status.command  = command_q;
	assign status.last     = last_q;
	assign status.zero     = zero_q;
	assign status.out_full = out_valid_q && !out_ready;

	// a closing binding always leaves a result and clear accumulators
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACC && last_q) |=> out_valid_q)
		else $error("result not raised on last binding");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACC && last_q) |=> (sum_x_q == 0 && sum_y_q == 0))
		else $error("accumulators not cleared after result");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_VAL && zero_q) |=> (value_q == 0))
		else $error("reading inside deadzone gave nonzero value");
	a_nooverwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACC && last_q) |-> !(out_valid_q && !out_ready))
		else $error("pending result overwritten");

endmodule

// ===== rtl/input_action_deadzone_mixer.sv =====
// ----------------------------------------------------------------------------
// input_action_deadzone_mixer
// Mixes per-frame action bindings into clamped X, Y and a pressed flag.
// ----------------------------------------------------------------------------
// after accept, a digital or unknown binding is weighted and accumulated; a trigger
// first runs the 16 step divider, a stick the 16 step square root and the divider
// (skipped when the reading is in the deadzone); a result turns valid at the
// accumulate edge of the last binding of a frame; one binding at a time, the next
// accepted in the cycle after accumulate; a waiting result holds a last binding's accumulate
// reset: asynchronous, clears deadzones, accumulators and the result valid
module input_action_deadzone_mixer #(
	parameter int ACCUM_BITS = iadm_pkg::ACCUM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_wdata,
	iadm_in_if.sink     in_ch,
	iadm_out_if.source  out_ch
);
	import iadm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer
	iadm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// arithmetic
	iadm_dpath #(.ACCUM_BITS(ACCUM_BITS)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_command     (in_ch.command),
		.in_held        (in_ch.held),
		.in_raw_main    (in_ch.raw_main),
		.in_raw_partner (in_ch.raw_partner),
		.in_to_y        (in_ch.to_y),
		.in_weight      (in_ch.weight),
		.in_last        (in_ch.last_binding),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.axis_x         (out_ch.axis_x),
		.axis_y         (out_ch.axis_y),
		.pressed        (out_ch.pressed)
	);

endmodule
